// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the skinning blend block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/ski_pkg.sv =====
`timescale 1ns / 1ps

package ski_pkg;

    // palette geometry
    localparam int PAL_MATRICES = 128;
    localparam int IDX_W      = $clog2(PAL_MATRICES);
    localparam int LANES      = 4;
    localparam int COLS       = 4;
    localparam int ROWS       = 4;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);
    localparam int RAM_DEPTH  = PAL_MATRICES * ROWS;
    localparam int ADDR_W     = IDX_W + ROW_W;

    // arithmetic widths
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int WT_W       = FRAC_W + 1;
    localparam int SUM_W      = FRAC_W + 2;
    localparam int BITS_PER_STEP = 5;
    localparam int DIV_STEPS  = 4;
    localparam int NUM_W      = BITS_PER_STEP * DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int PROD_W     = DATA_W + WT_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int SHR_W      = ACC_W - FRAC_W;
    localparam int JC_W       = 8;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = FIFO_AW + 1;

    // item codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_BLEND = 1'b1;

    // configuration register indexes
    localparam logic CFG_JOINT_COUNT = 1'b0;
    localparam logic CFG_BAD_SCALE   = 1'b1;

    localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << FRAC_W;

    typedef struct packed {
        logic               action;
        logic [6:0]         palette_entry;
        logic [3:0]         element_slot;
        logic signed [31:0] element_value;
        logic signed [23:0] weight_0;
        logic signed [23:0] weight_1;
        logic signed [23:0] weight_2;
        logic signed [23:0] weight_3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] col_0;
        logic signed [31:0] col_1;
        logic signed [31:0] col_2;
        logic signed [31:0] col_3;
        logic               last;
        logic               bad_weights;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [LANES-1:0][IDX_W-1:0]  idx;
        logic [LANES-1:0][FRAC_W-1:0] frac;
        logic [SUM_W-1:0]             sum;
        logic                         bad_mode;
    } t_div_req;

    typedef struct packed {
        logic [LANES-1:0][IDX_W-1:0] idx;
        logic [LANES-1:0][WT_W-1:0]  wt;
        logic                        bad;
    } t_wts;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } t_pal_wr;

endpackage

// ===== rtl/core/four_influence_skin_matrix_blend.sv =====
`timescale 1ns / 1ps
// rows of a blend issue one per cycle while the result queue has credit
// the divider takes the next blend as it hands weights on, so it divides while the 4 rows are read
// a palette write waits until no blend is pending ahead of its palette reads
// reset: control and queue cleared, joint_count 128, bad_scale_mode 1; palette keeps contents
module four_influence_skin_matrix_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ski_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ski_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata
);
    import ski_pkg::*;
    `include "assert_macros.svh"

    // configuration
    logic [JC_W-1:0] r_joint_count;
    logic            r_bad_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= JC_W'(128);
            r_bad_mode    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_JOINT_COUNT: r_joint_count <= i_cfg_wdata;
                CFG_BAD_SCALE:   r_bad_mode    <= i_cfg_wdata[0];
                default:         r_bad_mode    <= r_bad_mode;
            endcase
        end
    end

    // index clamp and weight sum
    t_div_req req;
    always_comb begin
        logic [LANES-1:0][23:0] w;
        int cnt_m1;
        int ip;
        w = {i_in_data.weight_3, i_in_data.weight_2, i_in_data.weight_1, i_in_data.weight_0};
        cnt_m1 = int'(r_joint_count);
        if (cnt_m1 > PAL_MATRICES) cnt_m1 = PAL_MATRICES;
        if (cnt_m1 < 1) cnt_m1 = 1;
        cnt_m1 = cnt_m1 - 1;
        req.sum      = '0;
        req.bad_mode = r_bad_mode;
        for (int k = 0; k < LANES; k++) begin
            ip = int'($signed(w[k][23:16]));
            if (ip < 0) ip = 0;
            if (ip > cnt_m1) ip = cnt_m1;
            req.idx[k]  = IDX_W'(ip);
            req.frac[k] = w[k][FRAC_W-1:0];
            req.sum     = req.sum + SUM_W'(w[k][FRAC_W-1:0]);
        end
    end

    // weight divider
    logic div_ready;
    logic div_idle;
    logic div_valid;
    logic w_free;
    t_wts div_wts;

    ski_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid && (i_in_data.action == ACT_BLEND)),
        .o_req_ready (div_ready),
        .i_req       (req),
        .o_idle      (div_idle),
        .o_wts_valid (div_valid),
        .i_wts_ready (w_free),
        .o_wts       (div_wts)
    );

    // weights held for the row sequence
    logic             r_w_valid;
    t_wts             r_w;
    logic [ROW_W-1:0] r_row;
    logic [OCC_W-1:0] r_occ;
    logic             issue;
    logic             w_release;
    logic             pop;

    assign issue     = r_w_valid && (r_occ < OCC_W'(FIFO_DEPTH));
    assign w_release = issue && (r_row == ROW_W'(ROWS - 1));
    assign w_free    = !r_w_valid || w_release;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_row     <= '0;
        end else begin
            if (div_valid && w_free) begin
                r_w_valid <= 1'b1;
            end else if (w_release) begin
                r_w_valid <= 1'b0;
            end
            if (issue) begin
                r_row <= r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_valid && w_free) begin
            r_w <= div_wts;
        end
    end

    // input handshake: writes only with no blend ahead of its reads
    logic in_acc;
    assign o_in_ready = (i_in_data.action == ACT_BLEND) ? div_ready
                                                        : (div_idle && !r_w_valid);
    assign in_acc     = i_in_valid && o_in_ready;

    t_pal_wr pal_wr;
    always_comb begin
        pal_wr.en   = in_acc && (i_in_data.action == ACT_WRITE) &&
                      (int'(i_in_data.palette_entry) < PAL_MATRICES);
        pal_wr.addr = {IDX_W'(i_in_data.palette_entry), i_in_data.element_slot[3:2]};
        pal_wr.col  = i_in_data.element_slot[1:0];
        pal_wr.data = i_in_data.element_value;
    end

    // read stage bookkeeping
    logic                       r_p1_valid;
    logic [ROW_W-1:0]           r_p1_row;
    logic                       r_p1_bad;
    logic [LANES-1:0][WT_W-1:0] r_p1_wt;
    logic                       r_p2_valid;
    logic [ROW_W-1:0]           r_p2_row;
    logic                       r_p2_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_row <= r_row;
        r_p1_bad <= r_w.bad;
        r_p1_wt  <= r_w.wt;
        r_p2_row <= r_p1_row;
        r_p2_bad <= r_p1_bad;
    end

    // one lane per influence
    logic [LANES-1:0][COLS-1:0][PROD_W-1:0] prod;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        ski_lane u_lane (
            .i_clk     (i_clk),
            .i_wr      (pal_wr),
            .i_rd_en   (issue),
            .i_rd_addr ({r_w.idx[k], r_row}),
            .i_wt      (r_p1_wt[k]),
            .o_prod    (prod[k])
        );
    end

    // merge lanes into one row result
    logic      m_valid;
    t_out_item m_item;

    ski_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p2_valid),
        .i_row   (r_p2_row),
        .i_bad   (r_p2_bad),
        .i_prod  (prod),
        .o_valid (m_valid),
        .o_item  (m_item)
    );

    // result queue, credited at issue so it never overflows
    t_out_item          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [OCC_W-1:0]   r_cnt;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rp];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_occ <= '0;
        end else begin
            if (m_valid) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + OCC_W'(m_valid) - OCC_W'(pop);
            r_occ <= r_occ + OCC_W'(issue) - OCC_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_valid) begin
            r_fifo[r_wp] <= m_item;
        end
    end

    // checks
    `ASSERT_CLK(a_occ_bound, i_clk, i_rst_n, r_occ <= OCC_W'(FIFO_DEPTH), "credit overrun")
    `ASSERT_CLK(a_cnt_le_occ, i_clk, i_rst_n, r_cnt <= r_occ, "queue holds uncredited rows")
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, m_valid && (r_cnt == OCC_W'(FIFO_DEPTH)), "push into full queue")
    `ASSERT_CLK(a_wr_idle, i_clk, i_rst_n, pal_wr.en |-> (!r_w_valid && div_idle), "palette write with blend pending")

endmodule

// ===== rtl/core/ski_ram.sv =====
`timescale 1ns / 1ps

module ski_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ski_div.sv =====
`timescale 1ns / 1ps

module ski_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ski_pkg::t_div_req i_req,
    output logic            o_idle,
    output logic            o_wts_valid,
    input  logic            i_wts_ready,
    output ski_pkg::t_wts   o_wts
);
    import ski_pkg::*;

    logic                              r_busy;
    logic                              r_hold;
    logic [CNT_W-1:0]                  r_cnt;
    logic [LANES-1:0][SUM_W-1:0]       r_rem;
    logic [LANES-1:0][NUM_W-1:0]       r_num;
    logic [LANES-1:0][NUM_W-1:0]       r_q;
    logic [SUM_W-1:0]                  r_sum;
    logic [LANES-1:0][IDX_W-1:0]       r_idx;
    logic                              r_bad;
    logic                              r_mode;

    logic [LANES-1:0][SUM_W-1:0]       n_rem;
    logic [LANES-1:0][NUM_W-1:0]       n_num;
    logic [LANES-1:0][NUM_W-1:0]       n_q;
    logic [LANES-1:0][NUM_W-1:0]       q_sel;
    logic                              handoff;
    logic                              load;

    // several restoring steps per cycle in every lane
    always_comb begin
        logic [SUM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] q;
        logic [SUM_W:0]   t;
        for (int k = 0; k < LANES; k++) begin
            rem = r_rem[k];
            num = r_num[k];
            q   = r_q[k];
            for (int s = 0; s < BITS_PER_STEP; s++) begin
                t = {rem, num[NUM_W-1]};
                if (t >= {1'b0, r_sum}) begin
                    rem = SUM_W'(t - {1'b0, r_sum});
                    q   = {q[NUM_W-2:0], 1'b1};
                end else begin
                    rem = t[SUM_W-1:0];
                    q   = {q[NUM_W-2:0], 1'b0};
                end
                num = {num[NUM_W-2:0], 1'b0};
            end
            n_rem[k] = rem;
            n_num[k] = num;
            n_q[k]   = q;
        end
    end

    // weights out, with the zero-sum replacement
    always_comb begin
        q_sel       = r_hold ? r_q : n_q;
        o_wts_valid = r_busy && (r_hold || (r_cnt == CNT_W'(DIV_STEPS - 1)));
        o_wts.idx   = r_idx;
        o_wts.bad   = r_bad;
        for (int k = 0; k < LANES; k++) begin
            if (r_bad) begin
                o_wts.wt[k] = ((k == 0) && r_mode) ? WT_ONE : '0;
            end else begin
                o_wts.wt[k] = q_sel[k][WT_W-1:0];
            end
        end
    end

    assign handoff     = o_wts_valid && i_wts_ready;
    assign o_req_ready = !r_busy || handoff;
    assign load        = i_req_valid && o_req_ready;
    assign o_idle      = !r_busy;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hold <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_hold <= 1'b0;
            r_cnt  <= '0;
        end else if (handoff) begin
            r_busy <= 1'b0;
            r_hold <= 1'b0;
        end else if (r_busy && !r_hold) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_hold <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [2*FRAC_W-1:0] nfull;
        if (load) begin
            for (int k = 0; k < LANES; k++) begin
                nfull    = {i_req.frac[k], FRAC_W'(0)};
                r_rem[k] <= SUM_W'(nfull >> NUM_W);
                r_num[k] <= nfull[NUM_W-1:0];
                r_q[k]   <= '0;
            end
            r_sum  <= i_req.sum;
            r_idx  <= i_req.idx;
            r_bad  <= (i_req.sum == '0);
            r_mode <= i_req.bad_mode;
        end else if (r_busy && !r_hold) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_q   <= n_q;
        end
    end

endmodule

// ===== rtl/core/ski_lane.sv =====
`timescale 1ns / 1ps

module ski_lane (
    input  logic                                    i_clk,
    input  ski_pkg::t_pal_wr                        i_wr,
    input  logic                                    i_rd_en,
    input  logic [ski_pkg::ADDR_W-1:0]              i_rd_addr,
    input  logic [ski_pkg::WT_W-1:0]                i_wt,
    output logic [ski_pkg::COLS-1:0][ski_pkg::PROD_W-1:0] o_prod
);
    import ski_pkg::*;

    logic [COLS-1:0][DATA_W-1:0] rdata;
    logic [COLS-1:0][PROD_W-1:0] r_prod;

    // one RAM per column of this lane's palette copy, holding that column for every row of every matrix
    for (genvar c = 0; c < COLS; c++) begin : g_col
        ski_ram #(
            .WIDTH (DATA_W),
            .DEPTH (RAM_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_wr.en && (i_wr.col == COL_W'(c))),
            .i_waddr (i_wr.addr),
            .i_wdata (i_wr.data),
            .i_re    (i_rd_en),
            .i_raddr (i_rd_addr),
            .o_rdata (rdata[c])
        );
    end

    // element times weight, registered
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < COLS; c++) begin
            r_prod[c] <= PROD_W'($signed(rdata[c]) * $signed({1'b0, i_wt}));
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/ski_merge.sv =====
`timescale 1ns / 1ps

module ski_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [ski_pkg::ROW_W-1:0] i_row,
    input  logic                i_bad,
    input  logic [ski_pkg::LANES-1:0][ski_pkg::COLS-1:0][ski_pkg::PROD_W-1:0] i_prod,
    output logic                o_valid,
    output ski_pkg::t_out_item  o_item
);
    import ski_pkg::*;

    logic                        r_valid;
    t_out_item                   r_item;
    logic [COLS-1:0][DATA_W-1:0] col_v;
    logic                        sat;

    // sum of lanes, floor to q16.16, clip to 32 bits
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [SHR_W-1:0] v;
        sat = 1'b0;
        for (int c = 0; c < COLS; c++) begin
            acc = '0;
            for (int k = 0; k < LANES; k++) begin
                acc = acc + ACC_W'($signed(i_prod[k][c]));
            end
            v = SHR_W'(acc >>> FRAC_W);
            if (v > SHR_W'(signed'(32'sh7fffffff))) begin
                col_v[c] = 32'h7fffffff;
                sat      = 1'b1;
            end else if (v < SHR_W'(signed'(32'sh80000000))) begin
                col_v[c] = 32'h80000000;
                sat      = 1'b1;
            end else begin
                col_v[c] = v[DATA_W-1:0];
            end
        end
    end

    // valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_item.row         <= i_row;
        r_item.col_0       <= col_v[0];
        r_item.col_1       <= col_v[1];
        r_item.col_2       <= col_v[2];
        r_item.col_3       <= col_v[3];
        r_item.last        <= (i_row == ROW_W'(ROWS - 1));
        r_item.bad_weights <= i_bad;
        r_item.saturated   <= sat;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
